### hdl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_BIG_ENDIAN  = 1'b0,
    REG_INCLUDE_BOM = 1'b1
  } reg_index_t;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Lead byte ranges
  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD4_MAX = 8'hF4;

  // Scalar limits
  localparam logic [20:0] MIN_THREE_BYTE = 21'h000800;
  localparam logic [20:0] SUPP_BASE      = 21'h010000;
  localparam logic [20:0] SCALAR_MAX     = 21'h10FFFF;
  localparam logic [20:0] SURR_FIRST     = 21'h00D800;
  localparam logic [20:0] SURR_LAST      = 21'h00DFFF;

  localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
  localparam logic [15:0] BOM_UNIT       = 16'hFEFF;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       msg_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       bad_input;
    logic       msg_end;
    logic       run_last;
  } out_item_t;

  // One classified request waiting to be turned into output bytes
  typedef struct packed {
    logic        is_err;
    logic        last;
    logic        bom;
    logic        pair;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } job_t;

endpackage

### hdl/u8u16_front.sv
// ----------------------------------------------------------------------------
// u8u16_front
// Decodes and validates the UTF-8 stream and queues one job per request
// that yields output.
// ----------------------------------------------------------------------------
module u8u16_front import u8u16_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     add_mark,
  input  logic     q_full,
  output logic     push,
  output job_t     push_job
);

  logic [1:0]  bytes_pending, bytes_pending_next;
  logic [20:0] scalar_acc, scalar_acc_next;
  logic [2:0]  seq_length, seq_length_next;
  logic        at_msg_start, at_msg_start_next;
  logic        dropping, dropping_next;

  logic [1:0]  step_pend;
  logic [20:0] step_acc;
  logic [2:0]  step_len;
  logic        seq_bad;
  logic        range_bad;
  logic        emit;
  logic [20:0] supp_off;
  logic [7:0]  b;
  logic        last;
  logic        accept;

  assign b        = in_data.in_byte;
  assign last     = in_data.msg_last;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign supp_off = step_acc - SUPP_BASE;

  always_comb begin
    step_pend = bytes_pending;
    step_acc  = scalar_acc;
    step_len  = seq_length;
    seq_bad   = 1'b0;
    if (bytes_pending == 2'd0) begin
      if (!b[7]) begin
        step_acc = {13'd0, b};
        step_len = 3'd1;
      end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
        step_pend = 2'd1;
        step_acc  = {16'd0, b[4:0]};
        step_len  = 3'd2;
      end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
        step_pend = 2'd2;
        step_acc  = {17'd0, b[3:0]};
        step_len  = 3'd3;
      end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
        step_pend = 2'd3;
        step_acc  = {18'd0, b[2:0]};
        step_len  = 3'd4;
      end else begin
        seq_bad = 1'b1;
      end
    end else begin
      if (b[7:6] != 2'b10) begin
        seq_bad = 1'b1;
      end else begin
        step_acc  = {scalar_acc[14:0], b[5:0]};
        step_pend = bytes_pending - 2'd1;
      end
    end
  end

  // Overlong, surrogate and out-of-range checks on a completed scalar
  assign range_bad = (step_len == 3'd3 && step_acc < MIN_THREE_BYTE) ||
                     (step_len == 3'd4 && step_acc < SUPP_BASE) ||
                     (step_acc > SCALAR_MAX) ||
                     (step_acc >= SURR_FIRST && step_acc <= SURR_LAST);

  always_comb begin
    bytes_pending_next = bytes_pending;
    scalar_acc_next    = scalar_acc;
    seq_length_next    = seq_length;
    at_msg_start_next  = at_msg_start;
    dropping_next      = dropping;
    emit               = 1'b0;
    push_job           = '0;
    push_job.last      = last;
    if (dropping) begin
      if (last) begin
        emit               = 1'b1;
        push_job.is_err    = 1'b1;
        dropping_next      = 1'b0;
        bytes_pending_next = '0;
        scalar_acc_next    = '0;
        seq_length_next    = '0;
        at_msg_start_next  = 1'b1;
      end
    end else if (seq_bad || (step_pend != 2'd0 && last) ||
                 (step_pend == 2'd0 && range_bad)) begin
      emit               = 1'b1;
      push_job.is_err    = 1'b1;
      dropping_next      = !last;
      bytes_pending_next = '0;
      scalar_acc_next    = '0;
      seq_length_next    = '0;
      if (last) begin
        at_msg_start_next = 1'b1;
      end
    end else if (step_pend != 2'd0) begin
      bytes_pending_next = step_pend;
      scalar_acc_next    = step_acc;
      seq_length_next    = step_len;
    end else begin
      emit               = 1'b1;
      bytes_pending_next = '0;
      scalar_acc_next    = '0;
      seq_length_next    = '0;
      at_msg_start_next  = last;
      push_job.bom       = at_msg_start && add_mark;
      if (step_acc < SUPP_BASE) begin
        push_job.unit0 = step_acc[15:0];
      end else begin
        push_job.pair  = 1'b1;
        push_job.unit0 = HIGH_SURR_BASE | {6'd0, supp_off[19:10]};
        push_job.unit1 = LOW_SURR_BASE | {6'd0, supp_off[9:0]};
      end
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= '0;
      scalar_acc    <= '0;
      seq_length    <= '0;
      at_msg_start  <= 1'b1;
      dropping      <= 1'b0;
    end else if (accept) begin
      bytes_pending <= bytes_pending_next;
      scalar_acc    <= scalar_acc_next;
      seq_length    <= seq_length_next;
      at_msg_start  <= at_msg_start_next;
      dropping      <= dropping_next;
    end
  end

endmodule

### hdl/u8u16_queue.sv
// ----------------------------------------------------------------------------
// u8u16_queue
// Small job queue between the decoder and the byte sequencer.
// ----------------------------------------------------------------------------
module u8u16_queue import u8u16_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [IW-1:0] wr_ptr;
  logic [IW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/u8u16_back.sv
// ----------------------------------------------------------------------------
// u8u16_back
// Turns queued jobs into output bytes or error reports, one per cycle while
// the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module u8u16_back import u8u16_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      msb_first,
  input  logic      head_valid,
  input  job_t      head_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [2:0]  byte_idx;
  logic [2:0]  last_idx;
  logic [1:0]  n_units;
  logic [15:0] cur_unit;
  logic        advance;
  logic        at_end;
  out_item_t   result;

  assign advance  = head_valid && (!out_valid || out_ready);
  assign n_units  = 2'd1 + {1'b0, head_job.bom} + {1'b0, head_job.pair};
  assign last_idx = head_job.is_err ? 3'd0 : {n_units, 1'b0} - 3'd1;
  assign at_end   = (byte_idx == last_idx);
  assign pop      = advance && at_end;

  // Units go out in the order: optional mark, first unit, optional second
  always_comb begin
    if (head_job.bom) begin
      case (byte_idx[2:1])
        2'd0:    cur_unit = BOM_UNIT;
        2'd1:    cur_unit = head_job.unit0;
        default: cur_unit = head_job.unit1;
      endcase
    end else begin
      cur_unit = (byte_idx[2:1] == 2'd0) ? head_job.unit0 : head_job.unit1;
    end
  end

  always_comb begin
    result          = '0;
    result.run_last = at_end;
    result.msg_end  = at_end && head_job.last;
    if (head_job.is_err) begin
      result.bad_input = 1'b1;
    end else begin
      result.has_byte = 1'b1;
      result.out_byte = (byte_idx[0] ^ msb_first) ? cur_unit[15:8] : cur_unit[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      byte_idx  <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        byte_idx  <= at_end ? 3'd0 : byte_idx + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hdl/utf8_to_utf16_transcoder_top.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_top
// Strict UTF-8 to UTF-16 transcoder with selectable byte order and an
// optional byte order mark.
// The first result of a request passes through the job queue and the output
// register. The byte sequencer gives one result per cycle while the output is
// not stalled: two bytes per request for one code unit, up to six for a mark
// plus a surrogate pair. Synchronous reset clears the decoder, the queue,
// the output valid flag and both configuration registers.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_top import u8u16_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_en,
  input  reg_index_t cfg_addr,
  input  logic       cfg_data
);

  logic msb_first;
  logic add_mark;
  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      msb_first <= 1'b0;
      add_mark  <= 1'b0;
    end else if (cfg_en) begin
      case (cfg_addr)
        REG_BIG_ENDIAN:  msb_first <= cfg_data;
        REG_INCLUDE_BOM: add_mark  <= cfg_data;
        default:         ;
      endcase
    end
  end

  u8u16_front front_i (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .add_mark (add_mark),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) queue_i (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  u8u16_back back_i (
    .clk        (clk),
    .rst        (rst),
    .msb_first  (msb_first),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### hdl/u8u16_checker.sv
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks on the transcoder output stream.
// ----------------------------------------------------------------------------
module u8u16_checker import u8u16_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result must hold until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // A result without a byte is always an error report, and ends its request.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.has_byte |-> out_data.bad_input && out_data.run_last)
    else $error("empty result that is not an error");

  // A data byte never carries the error flag.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.has_byte |-> !out_data.bad_input)
    else $error("data byte flagged as bad");

  // The end of a message is also the end of its request's results.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.msg_end |-> out_data.run_last)
    else $error("message end inside a request");

endmodule

bind utf8_to_utf16_transcoder_top u8u16_checker checker_i (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
